/* rtl/core/rc4_pkg.sv */
// Package for the RC4 stream cipher: field widths, microcode encodings,
// control and status structs and the microcode program ROM.
// Depends on nothing; the interfaces, sequencer, datapath and top level import it.
`default_nettype none

package rc4_pkg;

  localparam int BYTE_W   = 8;
  localparam int KLEN_W   = 9;
  localparam int SBOX_DEPTH = 256;
  localparam int PC_W     = 4;

  localparam logic [KLEN_W-1:0] KLEN_RESET = 9'd16;

  // Request types carried in req_type.
  localparam logic REQ_KEY  = 1'b0;
  localparam logic REQ_DATA = 1'b1;

  // Microcode step addresses.
  localparam logic [PC_W-1:0] ST_IDLE = 4'd0;
  localparam logic [PC_W-1:0] ST_P1   = 4'd1;
  localparam logic [PC_W-1:0] ST_P2   = 4'd2;
  localparam logic [PC_W-1:0] ST_P3   = 4'd3;
  localparam logic [PC_W-1:0] ST_I0   = 4'd4;
  localparam logic [PC_W-1:0] ST_I1   = 4'd5;
  localparam logic [PC_W-1:0] ST_K0   = 4'd6;
  localparam logic [PC_W-1:0] ST_K1   = 4'd7;
  localparam logic [PC_W-1:0] ST_K2   = 4'd8;
  localparam logic [PC_W-1:0] ST_K3   = 4'd9;
  localparam logic [PC_W-1:0] ST_K4   = 4'd10;

  // S-box read address source.
  typedef enum logic [1:0] {
    SRA_CTR,
    SRA_CTR_NEXT,
    SRA_JSUM,
    SRA_T
  } sra_sel_t;

  // S-box write address source.
  typedef enum logic {
    SWA_CTR,
    SWA_J
  } swa_sel_t;

  // S-box write data source.
  typedef enum logic [1:0] {
    SWD_CTR,
    SWD_RDATA,
    SWD_A
  } swd_sel_t;

  // Sequencing of the step counter.
  typedef enum logic [2:0] {
    JC_NEXT,
    JC_GOTO,
    JC_LOOP,
    JC_SCHED,
    JC_DISPATCH
  } jc_t;

  typedef struct packed {
    sra_sel_t        sra;
    logic            s_re;
    logic            s_we;
    swa_sel_t        swa;
    swd_sel_t        swd;
    logic            k_re;
    logic            k_key;
    logic            ld_a;
    logic            ld_b;
    logic            ld_j;
    logic            j_clr;
    logic            ctr_inc;
    logic            k_adv;
    logic            k_clr;
    logic            out_ld;
    jc_t             jc;
    logic [PC_W-1:0] target;
  } ucw_t;

  typedef struct packed {
    ucw_t uc;
    logic adv;
  } dp_ctrl_t;

  typedef struct packed {
    logic ctr_last;
    logic out_busy;
  } dp_stat_t;

  // The program. Counter ctr doubles as index i; a step that stalls
  // repeats with all its enables held off.
  function automatic ucw_t ucode_rom(input logic [PC_W-1:0] pc);
    ucw_t w;
    w = '0;
    unique case (pc)
      ST_IDLE: begin
        // Prefetch S[i+1] so that an accepted data word skips a step.
        w.s_re = 1'b1;
        w.sra  = SRA_CTR_NEXT;
        w.jc   = JC_DISPATCH;
      end
      ST_P1: begin
        w.ld_a = 1'b1;
        w.ld_j = 1'b1;
        w.s_re = 1'b1;
        w.sra  = SRA_JSUM;
      end
      ST_P2: begin
        w.ld_b = 1'b1;
        w.s_we = 1'b1;
        w.swa  = SWA_CTR;
        w.swd  = SWD_RDATA;
        w.s_re = 1'b1;
        w.sra  = SRA_T;
      end
      ST_P3: begin
        w.s_we   = 1'b1;
        w.swa    = SWA_J;
        w.swd    = SWD_A;
        w.out_ld = 1'b1;
        w.jc     = JC_GOTO;
        w.target = ST_IDLE;
      end
      ST_I0: begin
        w.s_we    = 1'b1;
        w.swa     = SWA_CTR;
        w.swd     = SWD_CTR;
        w.ctr_inc = 1'b1;
        w.jc      = JC_LOOP;
        w.target  = ST_I0;
      end
      ST_I1: begin
        w.j_clr  = 1'b1;
        w.k_clr  = 1'b1;
        w.jc     = JC_SCHED;
        w.target = ST_IDLE;
      end
      ST_K0: begin
        w.s_re = 1'b1;
        w.sra  = SRA_CTR;
        w.k_re = 1'b1;
      end
      ST_K1: begin
        w.ld_a  = 1'b1;
        w.ld_j  = 1'b1;
        w.k_key = 1'b1;
        w.s_re  = 1'b1;
        w.sra   = SRA_JSUM;
      end
      ST_K2: begin
        w.s_we = 1'b1;
        w.swa  = SWA_CTR;
        w.swd  = SWD_RDATA;
      end
      ST_K3: begin
        w.s_we    = 1'b1;
        w.swa     = SWA_J;
        w.swd     = SWD_A;
        w.ctr_inc = 1'b1;
        w.k_adv   = 1'b1;
        w.jc      = JC_LOOP;
        w.target  = ST_K0;
      end
      ST_K4: begin
        w.j_clr   = 1'b1;
        w.s_re    = 1'b1;
        w.sra     = SRA_CTR_NEXT;
        w.ctr_inc = 1'b1;
        w.jc      = JC_GOTO;
        w.target  = ST_P1;
      end
      default: begin
        w.jc     = JC_GOTO;
        w.target = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/rc4_if.sv */
// Valid/ready channel interfaces for the RC4 block: request words in,
// result words out. Depends on rc4_pkg for the field widths.
`default_nettype none

interface rc4_req_if;
  import rc4_pkg::*;
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [BYTE_W-1:0] key_index;
  logic [BYTE_W-1:0] value;
  logic              restart;
  modport source (output valid, req_type, key_index, value, restart, input ready);
  modport sink   (input valid, req_type, key_index, value, restart, output ready);
endinterface

interface rc4_res_if;
  import rc4_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  modport source (output valid, out_byte, input ready);
  modport sink   (input valid, out_byte, output ready);
endinterface

`default_nettype wire

/* rtl/core/rc4_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with a
// registered, enabled read (old data on a same-cycle collision). No dependencies.
`default_nettype none

module rc4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/rc4_useq.sv */
// Microcode sequencer: step counter, ROM lookup and jump logic.
// Depends on rc4_pkg for the program and the control structs.
`default_nettype none

module rc4_useq (
  input  logic              clk,
  input  logic              rst,
  input  logic              acc_data,
  input  logic              restart,
  input  rc4_pkg::dp_stat_t stat,
  output rc4_pkg::dp_ctrl_t ctrl,
  output logic              idle
);
  import rc4_pkg::*;

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  logic            sched;
  logic            stall;
  ucw_t            uc;

  assign uc    = ucode_rom(pc);
  assign stall = uc.out_ld && stat.out_busy;
  assign idle  = (pc == ST_IDLE);

  always_comb begin
    ctrl.uc  = uc;
    ctrl.adv = !stall;
  end

  always_comb begin
    unique case (uc.jc)
      JC_NEXT:     pc_next = pc + 4'd1;
      JC_GOTO:     pc_next = uc.target;
      JC_LOOP:     pc_next = stat.ctr_last ? (pc + 4'd1) : uc.target;
      JC_SCHED:    pc_next = sched ? (pc + 4'd1) : uc.target;
      JC_DISPATCH: pc_next = acc_data ? (restart ? ST_I0 : ST_P1) : pc;
      default:     pc_next = ST_IDLE;
    endcase
  end

  // After reset the initialisation pass runs with sched clear and ends in idle.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc    <= ST_I0;
      sched <= 1'b0;
    end else begin
      if (!stall) begin
        pc <= pc_next;
      end
      if (acc_data) begin
        sched <= restart;
      end
    end
  end

  a_dispatch_plain: assert property (@(posedge clk) disable iff (rst)
    acc_data && !restart |=> pc == ST_P1)
    else $error("data word without restart did not start keystream steps");

  a_dispatch_restart: assert property (@(posedge clk) disable iff (rst)
    acc_data && restart |=> pc == ST_I0 && sched)
    else $error("restart word did not start the key schedule");

  a_pc_bound: assert property (@(posedge clk) disable iff (rst)
    pc <= ST_K4)
    else $error("step counter left the program");

endmodule

`default_nettype wire

/* rtl/core/rc4_dpath.sv */
// Datapath: S-box and key store RAMs, indices, key position, swap registers
// and the output register. Depends on rc4_pkg and rc4_ram.
`default_nettype none

module rc4_dpath #(
  parameter int KEY_DEPTH = 256
) (
  input  logic                        clk,
  input  logic                        rst,
  input  rc4_pkg::dp_ctrl_t           ctrl,
  output rc4_pkg::dp_stat_t           stat,
  input  logic                        acc_key,
  input  logic                        acc_data,
  input  logic [rc4_pkg::BYTE_W-1:0]  key_index,
  input  logic [rc4_pkg::BYTE_W-1:0]  value,
  input  logic                        restart,
  input  logic                        cfg_we,
  input  logic [rc4_pkg::KLEN_W-1:0]  cfg_wdata,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rc4_pkg::BYTE_W-1:0]  out_byte
);
  import rc4_pkg::*;

  localparam int KAW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam logic [KLEN_W-1:0] KDEPTH_L = KLEN_W'(KEY_DEPTH);

  ucw_t              uc;
  logic              adv;

  logic [BYTE_W-1:0] ctr;
  logic [BYTE_W-1:0] jreg;
  logic [BYTE_W-1:0] a;
  logic [BYTE_W-1:0] b;
  logic [BYTE_W-1:0] val;
  logic [KAW-1:0]    kpos;
  logic [KLEN_W-1:0] key_length;
  logic [KLEN_W-1:0] klen_eff;
  logic [KLEN_W-1:0] kpos_p1;

  logic              s_we;
  logic              s_re;
  logic [BYTE_W-1:0] s_waddr;
  logic [BYTE_W-1:0] s_wdata;
  logic [BYTE_W-1:0] s_raddr;
  logic [BYTE_W-1:0] s_rdata;
  logic              k_we;
  logic              k_re;
  logic [BYTE_W-1:0] k_rdata;

  logic [BYTE_W-1:0] jsum;
  logic [BYTE_W-1:0] tsum_rd;
  logic [BYTE_W-1:0] tsum;
  logic [BYTE_W-1:0] ks;

  assign uc  = ctrl.uc;
  assign adv = ctrl.adv;

  always_comb begin
    jsum    = jreg + s_rdata + (uc.k_key ? k_rdata : '0);
    tsum_rd = a + s_rdata;
    tsum    = a + b;
    case (uc.sra)
      SRA_CTR:      s_raddr = ctr;
      SRA_CTR_NEXT: s_raddr = ctr + 8'd1;
      SRA_JSUM:     s_raddr = jsum;
      SRA_T:        s_raddr = tsum_rd;
    endcase
    s_waddr = (uc.swa == SWA_J) ? jreg : ctr;
    case (uc.swd)
      SWD_CTR:   s_wdata = ctr;
      SWD_RDATA: s_wdata = s_rdata;
      SWD_A:     s_wdata = a;
      default:   s_wdata = ctr;
    endcase
    s_we = uc.s_we && adv;
    s_re = uc.s_re && adv;
    k_re = uc.k_re && adv;
    k_we = acc_key && ({1'b0, key_index} < KDEPTH_L);
    // The keystream read was issued before the swap reached the RAM.
    if (tsum == jreg) begin
      ks = a;
    end else if (tsum == ctr) begin
      ks = b;
    end else begin
      ks = s_rdata;
    end
  end

  always_comb begin
    if (key_length == '0) begin
      klen_eff = 9'd1;
    end else if (key_length > KDEPTH_L) begin
      klen_eff = KDEPTH_L;
    end else begin
      klen_eff = key_length;
    end
    kpos_p1 = KLEN_W'(kpos) + 9'd1;
  end

  rc4_ram #(.WIDTH(BYTE_W), .DEPTH(SBOX_DEPTH)) u_sbox (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .re    (s_re),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  rc4_ram #(.WIDTH(BYTE_W), .DEPTH(KEY_DEPTH)) u_key (
    .clk   (clk),
    .we    (k_we),
    .waddr (key_index[KAW-1:0]),
    .wdata (value),
    .re    (k_re),
    .raddr (kpos),
    .rdata (k_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ctr        <= '0;
      jreg       <= '0;
      kpos       <= '0;
      key_length <= KLEN_RESET;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        key_length <= cfg_wdata;
      end
      if (acc_data && restart) begin
        ctr <= '0;
      end else if (acc_data || (uc.ctr_inc && adv)) begin
        ctr <= ctr + 8'd1;
      end
      if (uc.j_clr && adv) begin
        jreg <= '0;
      end else if (uc.ld_j && adv) begin
        jreg <= jsum;
      end
      if (uc.k_clr && adv) begin
        kpos <= '0;
      end else if (uc.k_adv && adv) begin
        kpos <= (kpos_p1 >= klen_eff) ? '0 : kpos_p1[KAW-1:0];
      end
      if (uc.out_ld && adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (uc.ld_a && adv) begin
      a <= s_rdata;
    end
    if (uc.ld_b && adv) begin
      b <= s_rdata;
    end
    if (acc_data) begin
      val <= value;
    end
    if (uc.out_ld && adv) begin
      out_byte <= val ^ ks;
    end
  end

  always_comb begin
    stat.ctr_last = (ctr == 8'hFF);
    stat.out_busy = out_valid && !out_ready;
  end

  a_kpos_range: assert property (@(posedge clk) disable iff (rst)
    k_re |-> KLEN_W'(kpos) < klen_eff)
    else $error("key position outside the configured key length");

  a_out_set: assert property (@(posedge clk) disable iff (rst)
    uc.out_ld && adv |=> out_valid)
    else $error("result word lost at output register load");

  a_restart_ctr: assert property (@(posedge clk) disable iff (rst)
    acc_data && restart |=> ctr == '0)
    else $error("index not cleared for the initialisation pass");

endmodule

`default_nettype wire

/* rtl/core/rc4_stream_cipher_top.sv */
// Top level of the RC4 stream cipher: request and result channels, the
// key length register port and the sequencer/datapath pair. Depends on
// rc4_pkg, rc4_if, rc4_ram, rc4_useq and rc4_dpath.
//
// The block takes request words on req and returns one result word on res
// for every data word; key-load words (req_type low) write value into the
// key store at key_index and give no result, and indices at or beyond
// KEY_DEPTH are dropped. A data word XORs value with the next keystream
// byte. A data word with restart set first rebuilds the S-box from the key
// store, using key_length bytes cyclically (zero counts as one, values above
// KEY_DEPTH as KEY_DEPTH), and clears i and j. Every key byte the schedule
// uses must have been loaded since reset. A data word runs through the
// chain of dependent accesses to the S-box RAM (one read and one write
// port): fetch S[i], fetch S[j], swap, fetch the keystream byte. A restart
// word first runs the identity fill and then the key schedule. After reset
// the block runs an identity fill of the S-box with req.ready low. The
// result sits in an output register, so the next word is accepted while it
// waits; the block stalls only when a new result is ready and the old one
// has not yet been taken. key_length is written through cfg_we/cfg_wdata
// and must only change while the block is idle.
`default_nettype none

module rc4_stream_cipher_top #(
  parameter int KEY_DEPTH = 256
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [rc4_pkg::KLEN_W-1:0] cfg_wdata,
  rc4_req_if.sink                    req,
  rc4_res_if.source                  res
);
  import rc4_pkg::*;

  dp_ctrl_t ctrl;
  dp_stat_t stat;
  logic     idle;
  logic     acc;
  logic     acc_key;
  logic     acc_data;

  // Words are taken only while the sequencer sits in its idle step.
  assign req.ready = idle;
  assign acc       = req.valid && req.ready;
  assign acc_key   = acc && (req.req_type == REQ_KEY);
  assign acc_data  = acc && (req.req_type == REQ_DATA);

  rc4_useq u_useq (
    .clk      (clk),
    .rst      (rst),
    .acc_data (acc_data),
    .restart  (req.restart),
    .stat     (stat),
    .ctrl     (ctrl),
    .idle     (idle)
  );

  rc4_dpath #(.KEY_DEPTH(KEY_DEPTH)) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .stat      (stat),
    .acc_key   (acc_key),
    .acc_data  (acc_data),
    .key_index (req.key_index),
    .value     (req.value),
    .restart   (req.restart),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_byte  (res.out_byte)
  );

endmodule

`default_nettype wire

/* dv/rc4_checker.sv */
// Checker for the RC4 stream cipher: follows the key length register and
// the request and result channels, predicts every cipher byte and compares.
// Depends on rc4_pkg and the channel interfaces in rc4_if.
`default_nettype none

module rc4_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [rc4_pkg::KLEN_W-1:0] cfg_wdata,
  rc4_req_if                         req,
  rc4_res_if                         res,
  output int                         fail_count,
  output int                         pending_words
);
  import rc4_pkg::*;

  logic [BYTE_W-1:0] perm    [SBOX_DEPTH];
  logic [BYTE_W-1:0] key_mem [SBOX_DEPTH];
  logic [BYTE_W-1:0] idx_i;
  logic [BYTE_W-1:0] idx_j;
  logic [KLEN_W-1:0] key_len;
  logic [BYTE_W-1:0] cipher_q [$];

  // Rebuild the permutation from the key store and clear both indices.
  function automatic void rekey();
    int                span;
    int                kpos;
    logic [BYTE_W-1:0] jj;
    logic [BYTE_W-1:0] t;
    span = int'(key_len);
    if (span == 0) span = 1;
    if (span > SBOX_DEPTH) span = SBOX_DEPTH;
    for (int n = 0; n < SBOX_DEPTH; n++) perm[n] = n[BYTE_W-1:0];
    jj   = '0;
    kpos = 0;
    for (int n = 0; n < SBOX_DEPTH; n++) begin
      jj      = jj + perm[n] + key_mem[kpos];
      t       = perm[n];
      perm[n] = perm[jj];
      perm[jj] = t;
      kpos++;
      if (kpos >= span) kpos = 0;
    end
    idx_i = '0;
    idx_j = '0;
  endfunction

  // Advance i and j, swap, and return the keystream byte.
  function automatic logic [BYTE_W-1:0] next_keystream();
    logic [BYTE_W-1:0] t;
    logic [BYTE_W-1:0] sum;
    idx_i       = idx_i + 8'd1;
    idx_j       = idx_j + perm[idx_i];
    t           = perm[idx_i];
    perm[idx_i] = perm[idx_j];
    perm[idx_j] = t;
    sum         = perm[idx_i] + perm[idx_j];
    return perm[sum];
  endfunction

  always @(posedge clk) begin : track
    logic [BYTE_W-1:0] want;
    if (rst) begin
      for (int n = 0; n < SBOX_DEPTH; n++) begin
        perm[n]    = n[BYTE_W-1:0];
        key_mem[n] = '0;
      end
      idx_i      = '0;
      idx_j      = '0;
      key_len    = KLEN_RESET;
      fail_count = 0;
      cipher_q.delete();
    end else begin
      // A result word cannot stem from a data word accepted at the same
      // edge, so results are checked first.
      if (res.valid && res.ready) begin
        if (cipher_q.size() == 0) begin
          $error("out_byte: expected none, actual 0x%02h", res.out_byte);
          fail_count++;
        end else begin
          want = cipher_q.pop_front();
          if (res.out_byte !== want) begin
            $error("out_byte: expected 0x%02h, actual 0x%02h", want, res.out_byte);
            fail_count++;
          end
        end
      end
      if (cfg_we) key_len = cfg_wdata;
      if (req.valid && req.ready) begin
        if (req.req_type == REQ_KEY) begin
          key_mem[req.key_index] = req.value;
        end else begin
          if (req.restart) rekey();
          cipher_q.push_back(req.value ^ next_keystream());
        end
      end
    end
    pending_words = cipher_q.size();
  end

endmodule

`default_nettype wire

/* dv/tb_top.sv */
// Top of the RC4 stream cipher testbench: clock, reset, stimulus, result
// back-pressure, watchdog and verdict. Depends on rc4_pkg, rc4_if, the
// block under test and rc4_checker.
`default_nettype none

module tb_top;
  import rc4_pkg::*;

  // Longest quiet stretch of a correct run is a restart word plus a result
  // stall at the sink; the limit is several times that.
  localparam int WATCHDOG_LIMIT = 6000;
  // Rough number of words sent in each random phase.
  localparam int PHASE_WORDS    = 190;
  // Pause after the last result before touching the register or finishing:
  // a key-load word may still be in flight, so this leaves ample margin.
  localparam int SETTLE_CYCLES  = 12;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [KLEN_W-1:0] cfg_wdata;

  rc4_req_if req_ch ();
  rc4_res_if res_ch ();

  int        fail_count;
  int        pending_words;
  int        quiet_cycles;
  bit        idle_on;
  bit [255:0] key_seen;

  rc4_stream_cipher_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .res       (res_ch)
  );

  rc4_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .req           (req_ch),
    .res           (res_ch),
    .fail_count    (fail_count),
    .pending_words (pending_words)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // The watchdog counts cycles with no word moving on either channel.
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    @(posedge clk);
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  // Result back-pressure: random stalls between open stretches, and no
  // stalls at all once idling is switched off.
  initial begin : sink_side
    int burst;
    res_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 2) == 0) begin
        burst = $urandom_range(1, 11);
        res_ch.ready = 1'b0;
      end else begin
        burst = $urandom_range(1, 16);
        res_ch.ready = 1'b1;
      end
      repeat (burst) @(negedge clk);
    end
  end

  // Offer one request word and hold it until the block takes it. Valid is
  // left high afterwards, so back-to-back words never drop it in between;
  // a gap, when one is drawn, lowers it at the following falling edge.
  task automatic push_word(input logic rtype, input logic [7:0] kidx,
                           input logic [7:0] val, input logic rst_flag);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      @(negedge clk);
      req_ch.valid     = 1'b0;
      req_ch.req_type  = 1'($urandom_range(0, 1));
      req_ch.key_index = 8'($urandom_range(0, 255));
      req_ch.value     = 8'($urandom_range(0, 255));
      req_ch.restart   = 1'($urandom_range(0, 1));
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_ch.valid     = 1'b1;
    req_ch.req_type  = rtype;
    req_ch.key_index = kidx;
    req_ch.value     = val;
    req_ch.restart   = rst_flag;
    if (rtype == REQ_KEY) key_seen[kidx] = 1'b1;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Drop valid and wait until every predicted result has come back, then
  // wait out SETTLE_CYCLES so the block can finish any trailing key-load word.
  task automatic settle();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (pending_words != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_key_length(input logic [KLEN_W-1:0] len);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = len;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // One random phase at a given key length. Each session makes sure every
  // key byte the schedule will read has been loaded, sometimes rewrites a
  // few key bytes (mostly inside the used range, now and then anywhere),
  // then streams data words. The first data word usually restarts the key
  // schedule; when it does not, the keystream simply carries on from the
  // previous state, which is a legal if odd sequence.
  task automatic run_phase(input logic [KLEN_W-1:0] len, input bit idle);
    int span;
    int sent;
    int burst;
    logic [7:0] kidx;
    settle();
    write_key_length(len);
    idle_on = idle;
    span = int'(len);
    if (span == 0) span = 1;
    if (span > 256) span = 256;
    sent = 0;
    while (sent < PHASE_WORDS) begin
      for (int k = 0; k < span; k++) begin
        if (!key_seen[k]) begin
          push_word(REQ_KEY, k[7:0], 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)));
          sent++;
        end
      end
      if ($urandom_range(0, 2) == 0) begin
        burst = $urandom_range(1, 8);
        repeat (burst) begin
          if ($urandom_range(0, 3) == 0) kidx = 8'($urandom_range(0, 255));
          else kidx = 8'($urandom_range(0, span - 1));
          push_word(REQ_KEY, kidx, 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)));
          sent++;
        end
      end
      burst = $urandom_range(4, 40);
      for (int d = 0; d < burst; d++) begin
        push_word(REQ_DATA, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  (d == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 15) == 0));
        sent++;
      end
    end
  endtask

  // Every input is driven from time zero so that nothing floats during reset.
  initial begin : stimulus
    logic [KLEN_W-1:0] lengths [7];
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    req_ch.valid     = 1'b0;
    req_ch.req_type  = REQ_KEY;
    req_ch.key_index = '0;
    req_ch.value     = '0;
    req_ch.restart   = 1'b0;
    idle_on          = 1'b1;
    key_seen         = '0;
    lengths = '{9'd16, 9'd256, 9'd0, 9'd7, 9'd511, 9'd2, 9'd1};

    repeat (6) @(negedge clk);
    rst = 1'b0;

    // The block runs an identity fill of its S-box after reset; wait for it to offer ready
    // before writing the register, and start with the shortest key.
    do @(posedge clk); while (!req_ch.ready);
    write_key_length(9'd1);

    // Data words before any restart run from the identity permutation;
    // the key index field is ignored on them.
    push_word(REQ_DATA, 8'hFF, 8'h00, 1'b0);
    push_word(REQ_DATA, 8'h00, 8'hFF, 1'b0);
    // Key loads at both ends of the store; the restart flag means nothing
    // on a key load.
    push_word(REQ_KEY, 8'h00, 8'h00, 1'b1);
    push_word(REQ_KEY, 8'hFF, 8'hFF, 1'b0);
    push_word(REQ_KEY, 8'h00, 8'hFF, 1'b0);
    // One-byte key, then a second restart after one more data word.
    push_word(REQ_DATA, 8'hFF, 8'h00, 1'b1);
    push_word(REQ_DATA, 8'h00, 8'hFF, 1'b0);
    push_word(REQ_DATA, 8'h5A, 8'hA5, 1'b1);
    // All-zero key.
    push_word(REQ_KEY, 8'h00, 8'h00, 1'b0);
    push_word(REQ_DATA, 8'hA5, 8'h5A, 1'b1);

    // A key length of zero behaves as one.
    settle();
    write_key_length(9'd0);
    push_word(REQ_DATA, 8'h3C, 8'h3C, 1'b1);
    push_word(REQ_DATA, 8'hC3, 8'hC3, 1'b0);

    // Random phases across short, full and over-range key lengths, then a
    // final phase with no idling on either side.
    foreach (lengths[p]) run_phase(lengths[p], 1'b1);
    run_phase(KLEN_W'($urandom_range(1, 300)), 1'b0);

    settle();
    if (fail_count == 0 && pending_words == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
